// ===== hw/rtl/two_axis_pid_follower_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the two-axis PID follower
// Every module that includes this file has ports named aclk and aresetn.
// ----------------------------------------------------------------------------
`ifndef TWO_AXIS_PID_FOLLOWER_UNIT_DEFINES_SVH
`define TWO_AXIS_PID_FOLLOWER_UNIT_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent
`define TPF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent
`define TPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tpf_pkg.sv =====
// ----------------------------------------------------------------------------
// tpf_pkg
// Shared types and constants of the two-axis PID follower.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpf_pkg;

    // Field widths
    localparam int POS_W      = 24;   // positions, offsets, errors
    localparam int TIME_W     = 32;   // time stamps and time step
    localparam int INTEG_W    = 32;   // integral, derivative, control
    localparam int GAIN_REG_W = 16;   // gain bits taken from a write
    localparam int TS_FRAC    = 16;   // fraction bits of a time value

    // Datapath widths
    localparam int MUL_W      = 33;              // signed multiplier operand
    localparam int PROD_W     = 2 * MUL_W;       // full product
    localparam int ACC_W      = 56;              // control sum and wide sums
    localparam int SUMPOS_W   = 52;              // position plus step
    localparam int DIFF_W     = POS_W + 1;       // error difference
    localparam int DIVIDEND_W = DIFF_W + TS_FRAC;
    localparam int DIV_STEPS  = DIVIDEND_W;      // one quotient bit a cycle
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = POS_W;

    // Saturation bounds
    localparam logic signed [POS_W-1:0]   POS_MAX = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0]   POS_MIN = 24'sh800000;
    localparam logic signed [INTEG_W-1:0] W32_MAX = 32'sh7FFFFFFF;
    localparam logic signed [INTEG_W-1:0] W32_MIN = 32'sh80000000;

    // Register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GAIN_PROP  = 3'd0,
        CFG_GAIN_INTEG = 3'd1,
        CFG_GAIN_DERIV = 3'd2,
        CFG_OFFSET_X   = 3'd3,
        CFG_OFFSET_Y   = 3'd4
    } cfg_addr_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL_EDT,
        ST_INTEG,
        ST_DIV_WAIT,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_SUM,
        ST_CTL,
        ST_MUL_STEP,
        ST_POS,
        ST_DONE
    } tpf_state_t;

    // Command to the multiply/divide unit
    typedef struct packed {
        logic                         mul_en;
        logic signed [MUL_W-1:0]      mul_a;
        logic signed [MUL_W-1:0]      mul_b;
        logic                         div_start;
        logic [DIVIDEND_W-1:0]        dividend;
        logic [TIME_W-1:0]            divisor;
    } mdu_req_t;

    // Status of the multiply/divide unit
    typedef struct packed {
        logic div_busy;
        logic div_done;
    } mdu_stat_t;

endpackage

// ===== hw/rtl/two_axis_pid_follower_unit.sv =====
// ----------------------------------------------------------------------------
// two_axis_pid_follower_unit
// Two-axis PID follower: from leader and own position and a time stamp it
// returns the follower's next position, one PID loop per axis.
//
//   channel   direction  handshake        payload
//   s_*       in         s_valid/s_ready  leader_x, leader_y, own_x, own_y,
//                                         time_now
//   m_*       out        m_valid/m_ready  new_x, new_y, zero_step
//   cfg_*     in         cfg_wr_en        cfg_addr, cfg_wdata
//
// Each request holds s_ready low until both axes are done; a zero time step
// skips the bit-serial divider, which otherwise runs once per axis.
// All multiplies share one registered 33x33 multiplier, one per cycle.
// The output register holds a result while m_ready is low; the next request
// is accepted meanwhile and its result waits until the register drains.
// Reset is synchronous and clears the integrals, last errors and time stamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_axis_pid_follower_unit #(
    parameter  int FRACTION_BITS = 12,
    localparam int GAIN_W = (FRACTION_BITS > tpf_pkg::GAIN_REG_W) ?
                            FRACTION_BITS : tpf_pkg::GAIN_REG_W
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input requests
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [tpf_pkg::POS_W-1:0]      s_leader_x,
    input  logic signed [tpf_pkg::POS_W-1:0]      s_leader_y,
    input  logic signed [tpf_pkg::POS_W-1:0]      s_own_x,
    input  logic signed [tpf_pkg::POS_W-1:0]      s_own_y,
    input  logic [tpf_pkg::TIME_W-1:0]            s_time_now,
    // results
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [tpf_pkg::POS_W-1:0]      m_new_x,
    output logic signed [tpf_pkg::POS_W-1:0]      m_new_y,
    output logic                                  m_zero_step,
    // configuration writes
    input  logic                                  cfg_wr_en,
    input  logic [tpf_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [tpf_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
    import tpf_pkg::*;

    localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = GAIN_W'((9 << FRACTION_BITS) / 10);
    localparam logic [GAIN_W-1:0] GAIN_INTEG_RST = GAIN_W'(1 << (FRACTION_BITS - 1));
    localparam logic [GAIN_W-1:0] GAIN_DERIV_RST = GAIN_W'(((1 << FRACTION_BITS) + 50) / 100);

    logic [GAIN_W-1:0]          gain_prop_reg;
    logic [GAIN_W-1:0]          gain_integ_reg;
    logic [GAIN_W-1:0]          gain_deriv_reg;
    logic signed [POS_W-1:0]    offset_x_reg;
    logic signed [POS_W-1:0]    offset_y_reg;

    logic                       m_valid_reg;
    logic signed [POS_W-1:0]    m_new_x_reg;
    logic signed [POS_W-1:0]    m_new_y_reg;
    logic                       m_zero_reg;

    logic                       core_idle;
    logic                       core_start;
    logic                       out_free;
    logic                       res_valid;
    logic signed [POS_W-1:0]    res_new_x;
    logic signed [POS_W-1:0]    res_new_y;
    logic                       res_zero;

    mdu_req_t                   mdu_req;
    mdu_stat_t                  mdu_stat;
    logic signed [PROD_W-1:0]   mdu_prod;
    logic [DIVIDEND_W-1:0]      mdu_quot;

    // Take a write into the addressed register; drop unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_prop_reg  <= GAIN_PROP_RST;
            gain_integ_reg <= GAIN_INTEG_RST;
            gain_deriv_reg <= GAIN_DERIV_RST;
            offset_x_reg   <= '0;
            offset_y_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_GAIN_PROP:  gain_prop_reg  <= GAIN_W'(cfg_wdata[GAIN_REG_W-1:0]);
                CFG_GAIN_INTEG: gain_integ_reg <= GAIN_W'(cfg_wdata[GAIN_REG_W-1:0]);
                CFG_GAIN_DERIV: gain_deriv_reg <= GAIN_W'(cfg_wdata[GAIN_REG_W-1:0]);
                CFG_OFFSET_X:   offset_x_reg   <= $signed(cfg_wdata[POS_W-1:0]);
                CFG_OFFSET_Y:   offset_y_reg   <= $signed(cfg_wdata[POS_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    // Accept a request whenever the sequencer is idle
    assign s_ready    = core_idle;
    assign core_start = s_valid && core_idle;
    assign out_free   = !m_valid_reg || m_ready;

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_new_x_reg <= res_new_x;
            m_new_y_reg <= res_new_y;
            m_zero_reg  <= res_zero;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_new_x     = m_new_x_reg;
    assign m_new_y     = m_new_y_reg;
    assign m_zero_step = m_zero_reg;

    tpf_ctrl #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (core_start),
        .lead_x     (s_leader_x),
        .lead_y     (s_leader_y),
        .own_x      (s_own_x),
        .own_y      (s_own_y),
        .time_now   (s_time_now),
        .idle       (core_idle),
        .gain_prop  (gain_prop_reg),
        .gain_integ (gain_integ_reg),
        .gain_deriv (gain_deriv_reg),
        .offset_x   (offset_x_reg),
        .offset_y   (offset_y_reg),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res_new_x  (res_new_x),
        .res_new_y  (res_new_y),
        .res_zero   (res_zero),
        .mdu_req    (mdu_req),
        .mdu_stat   (mdu_stat),
        .prod       (mdu_prod),
        .quot       (mdu_quot)
    );

    tpf_mdu u_mdu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mdu_req),
        .stat    (mdu_stat),
        .prod    (mdu_prod),
        .quot    (mdu_quot)
    );

endmodule

// ===== hw/rtl/tpf_mdu.sv =====
// ----------------------------------------------------------------------------
// tpf_mdu
// Shared multiply/divide unit: a registered 33x33 signed multiplier and a
// restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpf_mdu (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  tpf_pkg::mdu_req_t                    req,
    output tpf_pkg::mdu_stat_t                   stat,
    output logic signed [tpf_pkg::PROD_W-1:0]    prod,
    output logic [tpf_pkg::DIVIDEND_W-1:0]       quot
);
    import tpf_pkg::*;

    logic signed [PROD_W-1:0]   prod_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [DIV_CNT_W-1:0]       cnt_reg;
    logic [TIME_W-1:0]          rem_reg;
    logic [DIVIDEND_W-1:0]      quo_reg;
    logic [TIME_W-1:0]          dvsr_reg;

    logic [TIME_W:0]            rem_shift;
    logic [TIME_W:0]            rem_diff;
    logic                       rem_ge;
    logic [TIME_W-1:0]          rem_next;
    logic [DIVIDEND_W-1:0]      quo_next;

    // Shift in the next dividend bit and trial-subtract the divisor
    always_comb begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
        rem_diff  = rem_shift - {1'b0, dvsr_reg};
        rem_ge    = (rem_shift >= {1'b0, dvsr_reg});
        rem_next  = rem_ge ? rem_diff[TIME_W-1:0] : rem_shift[TIME_W-1:0];
        quo_next  = {quo_reg[DIVIDEND_W-2:0], rem_ge};
    end

    // Register the product when requested
    always_ff @(posedge aclk) begin
        if (req.mul_en) begin
            prod_reg <= req.mul_a * req.mul_b;
        end
    end

    // Divider control: count the steps and flag the last one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == DIV_CNT_W'(1));
            if (req.div_start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Divider datapath: load operands, then advance one bit a cycle
    always_ff @(posedge aclk) begin
        if (req.div_start) begin
            rem_reg  <= '0;
            quo_reg  <= req.dividend;
            dvsr_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign prod          = prod_reg;
    assign quot          = quo_reg;
    assign stat.div_busy = busy_reg;
    assign stat.div_done = done_reg;

endmodule

// ===== hw/rtl/tpf_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpf_ctrl
// Sequencer and datapath registers: walks each axis through error, integral,
// derivative, control sum and position step on the shared unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "two_axis_pid_follower_unit_defines.svh"

module tpf_ctrl #(
    parameter  int FRACTION_BITS = 12,
    localparam int GAIN_W = (FRACTION_BITS > tpf_pkg::GAIN_REG_W) ?
                            FRACTION_BITS : tpf_pkg::GAIN_REG_W
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // request capture
    input  logic                                  start,
    input  logic signed [tpf_pkg::POS_W-1:0]      lead_x,
    input  logic signed [tpf_pkg::POS_W-1:0]      lead_y,
    input  logic signed [tpf_pkg::POS_W-1:0]      own_x,
    input  logic signed [tpf_pkg::POS_W-1:0]      own_y,
    input  logic [tpf_pkg::TIME_W-1:0]            time_now,
    output logic                                  idle,
    // configuration
    input  logic [GAIN_W-1:0]                     gain_prop,
    input  logic [GAIN_W-1:0]                     gain_integ,
    input  logic [GAIN_W-1:0]                     gain_deriv,
    input  logic signed [tpf_pkg::POS_W-1:0]      offset_x,
    input  logic signed [tpf_pkg::POS_W-1:0]      offset_y,
    // result
    input  logic                                  out_free,
    output logic                                  res_valid,
    output logic signed [tpf_pkg::POS_W-1:0]      res_new_x,
    output logic signed [tpf_pkg::POS_W-1:0]      res_new_y,
    output logic                                  res_zero,
    // shared unit
    output tpf_pkg::mdu_req_t                     mdu_req,
    input  tpf_pkg::mdu_stat_t                    mdu_stat,
    input  logic signed [tpf_pkg::PROD_W-1:0]     prod,
    input  logic [tpf_pkg::DIVIDEND_W-1:0]        quot
);
    import tpf_pkg::*;

    localparam logic signed [PROD_W-1:0] HALF_TS  = PROD_W'(1) << (TS_FRAC - 1);
    localparam logic signed [ACC_W-1:0]  CTL_HALF = ACC_W'(1) << (FRACTION_BITS - 1);

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUMPOS_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > SUMPOS_W'(POS_MAX)) begin
            r = POS_MAX;
        end else if (v < SUMPOS_W'(POS_MIN)) begin
            r = POS_MIN;
        end else begin
            r = $signed(v[POS_W-1:0]);
        end
        return r;
    endfunction

    function automatic logic signed [INTEG_W-1:0] sat_w32(input logic signed [ACC_W-1:0] v);
        logic signed [INTEG_W-1:0] r;
        if (v > ACC_W'(W32_MAX)) begin
            r = W32_MAX;
        end else if (v < ACC_W'(W32_MIN)) begin
            r = W32_MIN;
        end else begin
            r = $signed(v[INTEG_W-1:0]);
        end
        return r;
    endfunction

    // Control state
    tpf_state_t state_reg, state_next;
    logic       axis_reg;

    // Per-item and per-axis registers
    logic signed [POS_W-1:0]    lead_reg [2];
    logic signed [POS_W-1:0]    own_reg [2];
    logic signed [POS_W-1:0]    newpos_reg [2];
    logic [TIME_W-1:0]          dt_reg;
    logic                       zero_reg;
    logic signed [POS_W-1:0]    err_reg;
    logic                       div_neg_reg;
    logic signed [INTEG_W-1:0]  deriv_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [INTEG_W-1:0]  ctl_reg;

    // Controller memory across items
    logic signed [INTEG_W-1:0]  integ_reg [2];
    logic signed [POS_W-1:0]    last_err_reg [2];
    logic [TIME_W-1:0]          last_time_reg;

    // Datapath terms
    logic signed [POS_W-1:0]    lead_sel;
    logic signed [POS_W-1:0]    own_sel;
    logic signed [POS_W-1:0]    off_sel;
    logic signed [INTEG_W-1:0]  integ_sel;
    logic signed [POS_W-1:0]    last_err_sel;
    logic signed [POS_W+1:0]    err_wide;
    logic signed [POS_W-1:0]    err_sat;
    logic signed [PROD_W-1:0]   prod_round;
    logic signed [ACC_W-1:0]    integ_sum;
    logic signed [INTEG_W-1:0]  integ_new;
    logic signed [DIFF_W-1:0]   diff;
    logic                       diff_neg;
    logic [DIFF_W-1:0]          diff_mag;
    logic signed [ACC_W-1:0]    deriv_mag;
    logic signed [ACC_W-1:0]    deriv_wide;
    logic signed [INTEG_W-1:0]  deriv_new;
    logic signed [ACC_W-1:0]    acc_prod;
    logic signed [ACC_W-1:0]    ctl_round;
    logic signed [INTEG_W-1:0]  ctl_new;
    logic signed [SUMPOS_W-1:0] pos_sum;
    logic signed [POS_W-1:0]    pos_new;

    // Select the current axis and form the arithmetic around the shared unit
    always_comb begin
        lead_sel     = lead_reg[axis_reg];
        own_sel      = own_reg[axis_reg];
        off_sel      = axis_reg ? offset_y : offset_x;
        integ_sel    = integ_reg[axis_reg];
        last_err_sel = last_err_reg[axis_reg];

        err_wide = (POS_W+2)'(lead_sel) + (POS_W+2)'(off_sel) - (POS_W+2)'(own_sel);
        err_sat  = sat_pos(SUMPOS_W'(err_wide));

        // round to nearest, ties upward, on the time fraction
        prod_round = (prod + HALF_TS) >>> TS_FRAC;
        integ_sum  = ACC_W'(integ_sel) + $signed(prod_round[ACC_W-1:0]);
        integ_new  = sat_w32(integ_sum);

        diff     = DIFF_W'(err_reg) - DIFF_W'(last_err_sel);
        diff_neg = diff[DIFF_W-1];
        diff_mag = diff_neg ? DIFF_W'(-diff) : DIFF_W'(diff);

        deriv_mag  = $signed(ACC_W'(quot));
        deriv_wide = div_neg_reg ? -deriv_mag : deriv_mag;
        deriv_new  = sat_w32(deriv_wide);

        acc_prod  = $signed(prod[ACC_W-1:0]);
        ctl_round = (acc_reg + CTL_HALF) >>> FRACTION_BITS;
        ctl_new   = sat_w32(ctl_round);

        pos_sum = SUMPOS_W'(own_sel) + $signed(prod_round[SUMPOS_W-1:0]);
        pos_new = sat_pos(pos_sum);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR:      state_next = ST_MUL_EDT;
            ST_MUL_EDT:  state_next = ST_INTEG;
            ST_INTEG:    state_next = zero_reg ? ST_MUL_P : ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (mdu_stat.div_done) begin
                    state_next = ST_MUL_P;
                end
            end
            ST_MUL_P:    state_next = ST_MUL_I;
            ST_MUL_I:    state_next = ST_MUL_D;
            ST_MUL_D:    state_next = ST_SUM;
            ST_SUM:      state_next = ST_CTL;
            ST_CTL:      state_next = ST_MUL_STEP;
            ST_MUL_STEP: state_next = ST_POS;
            ST_POS:      state_next = axis_reg ? ST_DONE : ST_ERR;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs: operands for the shared unit and handshake flags
    always_comb begin
        mdu_req   = '0;
        idle      = 1'b0;
        res_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: idle = 1'b1;
            ST_MUL_EDT: begin
                mdu_req.mul_en = 1'b1;
                mdu_req.mul_a  = MUL_W'(err_reg);
                mdu_req.mul_b  = $signed({1'b0, dt_reg});
            end
            ST_INTEG: begin
                mdu_req.div_start = !zero_reg;
                mdu_req.dividend  = {diff_mag, TS_FRAC'(0)};
                mdu_req.divisor   = dt_reg;
            end
            ST_MUL_P: begin
                mdu_req.mul_en = 1'b1;
                mdu_req.mul_a  = $signed(MUL_W'(gain_prop));
                mdu_req.mul_b  = MUL_W'(err_reg);
            end
            ST_MUL_I: begin
                mdu_req.mul_en = 1'b1;
                mdu_req.mul_a  = $signed(MUL_W'(gain_integ));
                mdu_req.mul_b  = MUL_W'(integ_sel);
            end
            ST_MUL_D: begin
                mdu_req.mul_en = 1'b1;
                mdu_req.mul_a  = $signed(MUL_W'(gain_deriv));
                mdu_req.mul_b  = MUL_W'(deriv_reg);
            end
            ST_MUL_STEP: begin
                mdu_req.mul_en = 1'b1;
                mdu_req.mul_a  = MUL_W'(ctl_reg);
                mdu_req.mul_b  = $signed({1'b0, dt_reg});
            end
            ST_DONE: res_valid = out_free;
            default: mdu_req = '0;
        endcase
    end

    // Advance state and axis
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            axis_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == ST_IDLE) && start) begin
                axis_reg <= 1'b0;
            end else if ((state_reg == ST_POS) && !axis_reg) begin
                axis_reg <= 1'b1;
            end
        end
    end

    // Hold integrals, last errors and last time stamp across requests
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg[0]    <= '0;
            integ_reg[1]    <= '0;
            last_err_reg[0] <= '0;
            last_err_reg[1] <= '0;
            last_time_reg   <= '0;
        end else begin
            if ((state_reg == ST_IDLE) && start) begin
                last_time_reg <= time_now;
            end
            if (state_reg == ST_INTEG) begin
                integ_reg[axis_reg] <= integ_new;
            end
            if (state_reg == ST_POS) begin
                last_err_reg[axis_reg] <= err_reg;
            end
        end
    end

    // Working registers of the current request
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    lead_reg[0] <= lead_x;
                    lead_reg[1] <= lead_y;
                    own_reg[0]  <= own_x;
                    own_reg[1]  <= own_y;
                    dt_reg      <= time_now - last_time_reg;
                    zero_reg    <= (time_now == last_time_reg);
                end
            end
            ST_ERR: err_reg <= err_sat;
            ST_INTEG: begin
                div_neg_reg <= diff_neg;
                if (zero_reg) begin
                    deriv_reg <= '0;
                end
            end
            ST_DIV_WAIT: begin
                if (mdu_stat.div_done) begin
                    deriv_reg <= deriv_new;
                end
            end
            ST_MUL_I:  acc_reg <= acc_prod;
            ST_MUL_D:  acc_reg <= acc_reg + acc_prod;
            ST_SUM:    acc_reg <= acc_reg + acc_prod;
            ST_CTL:    ctl_reg <= ctl_new;
            ST_POS:    newpos_reg[axis_reg] <= pos_new;
            default: begin
            end
        endcase
    end

    assign res_new_x = newpos_reg[0];
    assign res_new_y = newpos_reg[1];
    assign res_zero  = zero_reg;

    `TPF_ASSERT_SAME(a_div_wait_covered, state_reg == ST_DIV_WAIT, mdu_stat.div_busy || mdu_stat.div_done, "waiting on a divider that is not running")
    `TPF_ASSERT_SAME(a_div_nonzero_step, mdu_req.div_start, dt_reg != '0, "division started with a zero time step")
    `TPF_ASSERT_NEXT(a_axis_switch, (state_reg == ST_POS) && !axis_reg, (state_reg == ST_ERR) && axis_reg, "x axis did not hand over to y axis")
    `TPF_ASSERT_NEXT(a_result_then_idle, res_valid, state_reg == ST_IDLE, "sequencer not idle after delivering a result")

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-axis PID follower. A queue of position
// requests feeds a valid/ready driver; a monitor compares every result with
// a cycle-free fixed-point model of both PID loops, run on each accepted
// request. Phases change the gains and offsets while the unit is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import tpf_pkg::*;

    localparam int     FRAC_BITS   = 12;
    localparam int     HOLD_CYCLES = 400;   // long result back-pressure
    localparam int     STALL_LIMIT = 3000;  // cycles with no handshake
    localparam longint POS_HI = (longint'(1) <<< (POS_W - 1)) - 1;
    localparam longint POS_LO = -(longint'(1) <<< (POS_W - 1));
    localparam longint W32_HI = (longint'(1) <<< (INTEG_W - 1)) - 1;
    localparam longint W32_LO = -(longint'(1) <<< (INTEG_W - 1));
    localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_SPARE = CFG_ADDR_W'(CFG_OFFSET_Y + 1);
    localparam logic [CFG_ADDR_W-1:0] CFG_LAST_SPARE  = {CFG_ADDR_W{1'b1}};

    typedef struct packed {
        logic signed [POS_W-1:0] leader_x;
        logic signed [POS_W-1:0] leader_y;
        logic signed [POS_W-1:0] own_x;
        logic signed [POS_W-1:0] own_y;
        logic [TIME_W-1:0]       time_now;
    } pos_req_t;

    typedef struct packed {
        logic signed [POS_W-1:0] new_x;
        logic signed [POS_W-1:0] new_y;
        logic                    zero_step;
    } pos_result_t;

    // DUT signals; the inputs are known from time zero
    logic                    aclk        = 1'b0;
    logic                    aresetn     = 1'b0;
    logic                    s_valid     = 1'b0;
    logic                    s_ready;
    logic signed [POS_W-1:0] s_leader_x  = '0;
    logic signed [POS_W-1:0] s_leader_y  = '0;
    logic signed [POS_W-1:0] s_own_x     = '0;
    logic signed [POS_W-1:0] s_own_y     = '0;
    logic [TIME_W-1:0]       s_time_now  = '0;
    logic                    m_valid;
    logic                    m_ready     = 1'b0;
    logic signed [POS_W-1:0] m_new_x;
    logic signed [POS_W-1:0] m_new_y;
    logic                    m_zero_step;
    logic                    cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0]   cfg_addr    = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata   = '0;

    // Follower model state and its copy of the registers
    longint            gain_p = (longint'(9) <<< FRAC_BITS) / 10;
    longint            gain_i = longint'(1) <<< (FRAC_BITS - 1);
    longint            gain_d = ((longint'(1) <<< FRAC_BITS) + 50) / 100;
    longint            axis_off[2]      = '{0, 0};
    longint            axis_integ[2]    = '{0, 0};
    longint            axis_last_err[2] = '{0, 0};
    logic [TIME_W-1:0] last_stamp = '0;

    // Stimulus and checking bookkeeping
    pos_req_t          pending_reqs[$];
    pos_result_t       pos_expected[$];
    int                error_count   = 0;
    int                quiet_cycles  = 0;
    int                send_gap      = 0;
    int                send_gap_max  = 8;
    int                take_gap      = 0;
    int                take_gap_max  = 8;
    bit                req_done      = 1'b0;
    bit                res_done      = 1'b0;
    bit                long_hold_req = 1'b0;
    longint            trk_x = 0;
    longint            trk_y = 0;
    logic [TIME_W-1:0] trk_stamp = '0;

    two_axis_pid_follower_unit #(
        .FRACTION_BITS(FRAC_BITS)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_leader_x  (s_leader_x),
        .s_leader_y  (s_leader_y),
        .s_own_x     (s_own_x),
        .s_own_y     (s_own_y),
        .s_time_now  (s_time_now),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_new_x     (m_new_x),
        .m_new_y     (m_new_y),
        .m_zero_step (m_zero_step),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Round to nearest with ties upward, then drop s fraction bits
    function automatic longint round_half_up(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // One PID loop: update the axis state and return the new position
    function automatic longint axis_next(int ax, longint lead, longint own, longint dt);
        longint err;
        longint deriv;
        longint ctl;
        longint step;
        err = clamp(lead + axis_off[ax] - own, POS_LO, POS_HI);
        axis_integ[ax] = clamp(axis_integ[ax] + round_half_up(err * dt, TS_FRAC),
                               W32_LO, W32_HI);
        deriv = 0;
        if (dt != 0) begin
            deriv = clamp(((err - axis_last_err[ax]) * (longint'(1) <<< TS_FRAC)) / dt,
                          W32_LO, W32_HI);
        end
        ctl = gain_p * err + gain_i * axis_integ[ax] + gain_d * deriv;
        ctl = clamp(round_half_up(ctl, FRAC_BITS), W32_LO, W32_HI);
        step = round_half_up(ctl * dt, TS_FRAC);
        axis_last_err[ax] = err;
        return clamp(own + step, POS_LO, POS_HI);
    endfunction

    function automatic pos_result_t follow_step(pos_req_t r);
        pos_result_t       res;
        logic [TIME_W-1:0] dt;
        longint            dt_wide;
        dt = r.time_now - last_stamp;
        dt_wide = longint'(dt);
        res.new_x = POS_W'(axis_next(0, longint'($signed(r.leader_x)),
                                     longint'($signed(r.own_x)), dt_wide));
        res.new_y = POS_W'(axis_next(1, longint'($signed(r.leader_y)),
                                     longint'($signed(r.own_y)), dt_wide));
        res.zero_step = (dt == 0);
        last_stamp = r.time_now;
        return res;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        $display("ERROR @%0t ns: %s", $time, msg);
    endtask

    // Write one register; the enable stays high across back-to-back writes
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_GAIN_PROP:  gain_p = longint'(val[GAIN_REG_W-1:0]);
            CFG_GAIN_INTEG: gain_i = longint'(val[GAIN_REG_W-1:0]);
            CFG_GAIN_DERIV: gain_d = longint'(val[GAIN_REG_W-1:0]);
            CFG_OFFSET_X:   axis_off[0] = longint'($signed(val));
            CFG_OFFSET_Y:   axis_off[1] = longint'($signed(val));
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic end_writes();
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Gains carry junk in the unused upper bits; a spare index gets a write too
    task automatic random_config(input int gain_cap, input bit wide_offsets);
        logic [CFG_DATA_W-1:0] val;
        val = CFG_DATA_W'($urandom);
        val[GAIN_REG_W-1:0] = GAIN_REG_W'($urandom_range(0, gain_cap));
        write_reg(CFG_GAIN_PROP, val);
        val = CFG_DATA_W'($urandom);
        val[GAIN_REG_W-1:0] = GAIN_REG_W'($urandom_range(0, gain_cap));
        write_reg(CFG_GAIN_INTEG, val);
        val = CFG_DATA_W'($urandom);
        val[GAIN_REG_W-1:0] = GAIN_REG_W'($urandom_range(0, gain_cap));
        write_reg(CFG_GAIN_DERIV, val);
        write_reg(CFG_OFFSET_X, CFG_DATA_W'(wide_offsets ? $urandom :
                                $urandom_range(0, 1 << 17) - (1 << 16)));
        write_reg(CFG_OFFSET_Y, CFG_DATA_W'(wide_offsets ? $urandom :
                                $urandom_range(0, 1 << 17) - (1 << 16)));
        write_reg(CFG_ADDR_W'($urandom_range(CFG_FIRST_SPARE, CFG_LAST_SPARE)),
                  CFG_DATA_W'($urandom));
        end_writes();
    endtask

    function automatic longint rand_delta(longint span);
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    task automatic push_req(input longint lx, input longint ly, input longint ox,
                            input longint oy, input logic [TIME_W-1:0] stamp);
        pos_req_t r;
        r.leader_x = POS_W'(lx);
        r.leader_y = POS_W'(ly);
        r.own_x    = POS_W'(ox);
        r.own_y    = POS_W'(oy);
        r.time_now = stamp;
        pending_reqs.push_back(r);
        trk_stamp = stamp;
    endtask

    // Mostly a smooth leader track with the follower near its slot; some noise
    task automatic gen_track_req(output pos_req_t r);
        int     pick;
        longint spread;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            r.leader_x = POS_W'($urandom);
            r.leader_y = POS_W'($urandom);
            r.own_x    = POS_W'($urandom);
            r.own_y    = POS_W'($urandom);
            r.time_now = $urandom;
            trk_stamp  = r.time_now;
        end else begin
            spread = (pick < 22) ? (longint'(1) <<< 20) : (longint'(1) <<< 13);
            trk_x = clamp(trk_x + rand_delta(4096), POS_LO / 2, POS_HI / 2);
            trk_y = clamp(trk_y + rand_delta(4096), POS_LO / 2, POS_HI / 2);
            r.leader_x = POS_W'(trk_x);
            r.leader_y = POS_W'(trk_y);
            r.own_x = POS_W'(clamp(trk_x + axis_off[0] + rand_delta(spread), POS_LO, POS_HI));
            r.own_y = POS_W'(clamp(trk_y + axis_off[1] + rand_delta(spread), POS_LO, POS_HI));
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                // repeat the stamp: zero time step
            end else if (pick < 6) begin
                trk_stamp = trk_stamp - $urandom_range(1, 1 << 20);
            end else begin
                trk_stamp = trk_stamp + $urandom_range(1, 1 << 14);
            end
            r.time_now = trk_stamp;
        end
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_valid || pos_expected.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_phase(input int n_items, input int s_gap, input int m_gap,
                             input bit hold);
        pos_req_t r;
        send_gap_max = s_gap;
        take_gap_max = m_gap;
        for (int i = 0; i < n_items; i++) begin
            gen_track_req(r);
            pending_reqs.push_back(r);
        end
        if (hold) begin
            repeat (20) @(posedge aclk);
            long_hold_req = 1'b1;
        end
        wait_idle();
    endtask

    // Request driver: hold a request until taken, then idle for a drawn gap
    always @(negedge aclk) begin : drive_blk
        pos_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_done) begin
            if (req_done) begin
                req_done = 1'b0;
                send_gap = $urandom_range(0, send_gap_max);
            end
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                nxt = pending_reqs.pop_front();
                s_leader_x <= nxt.leader_x;
                s_leader_y <= nxt.leader_y;
                s_own_x    <= nxt.own_x;
                s_own_y    <= nxt.own_y;
                s_time_now <= nxt.time_now;
                s_valid    <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver: stall a drawn number of cycles after each result
    always @(negedge aclk) begin
        if (res_done) begin
            res_done = 1'b0;
            take_gap = $urandom_range(0, take_gap_max);
        end
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            take_gap = HOLD_CYCLES;
        end
        if (take_gap > 0) begin
            take_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Check results, predict accepted requests, watch for a hang
    always @(posedge aclk) begin : mon_blk
        pos_req_t    acc;
        pos_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                res_done = 1'b1;
                if (pos_expected.size() == 0) begin
                    report_error($sformatf("result with none pending: x %0d y %0d",
                                           m_new_x, m_new_y));
                end else begin
                    want = pos_expected.pop_front();
                    if (m_new_x !== want.new_x)
                        report_error($sformatf("new_x expected %0d got %0d",
                                               $signed(want.new_x), m_new_x));
                    if (m_new_y !== want.new_y)
                        report_error($sformatf("new_y expected %0d got %0d",
                                               $signed(want.new_y), m_new_y));
                    if (m_zero_step !== want.zero_step)
                        report_error($sformatf("zero_step expected %0b got %0b",
                                               want.zero_step, m_zero_step));
                end
            end
            if (s_valid && s_ready) begin
                req_done = 1'b1;
                acc.leader_x = s_leader_x;
                acc.leader_y = s_leader_y;
                acc.own_x    = s_own_x;
                acc.own_y    = s_own_y;
                acc.time_now = s_time_now;
                pos_expected.push_back(follow_step(acc));
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset gains: extremes, error saturation, zero and wrapped steps
        push_req(0, 0, 0, 0, 32'h0000_0000);
        push_req(POS_HI, POS_LO, POS_LO, POS_HI, 32'h0000_0290);
        push_req(POS_LO, POS_HI, POS_HI, POS_LO, 32'h0000_0520);
        push_req(POS_LO, POS_HI, POS_HI, POS_LO, 32'h0000_0520);
        push_req(4096, -4096, 0, 0, 32'h0000_07A0);
        push_req(4096, -4096, 0, 0, 32'h0000_0100);
        push_req(POS_HI, POS_LO, POS_HI - 10, POS_LO + 10, 32'hFFFF_FFFF);
        push_req(POS_LO, POS_HI, POS_HI, POS_LO, 32'h0000_0000);
        push_req(POS_HI, POS_HI, POS_HI, POS_HI, 32'h0000_0001);
        push_req(POS_LO, POS_LO, POS_LO, POS_LO, 32'h0001_0001);
        push_req(8192, 8192, 0, 0, 32'h0001_0290);
        push_req(-8192, -8192, 0, 0, 32'h0001_0520);
        push_req(100, -100, 50, -50, 32'h0001_0520);
        push_req(0, 0, 0, 0, 32'h8001_0520);
        run_phase(220, 8, 8, 1'b0);

        // All gains zero, offsets at opposite extremes, no idling
        write_reg(CFG_GAIN_PROP, 24'hFF0000);
        write_reg(CFG_GAIN_INTEG, 24'hFF0000);
        write_reg(CFG_GAIN_DERIV, 24'hFF0000);
        write_reg(CFG_OFFSET_X, CFG_DATA_W'(POS_HI));
        write_reg(CFG_OFFSET_Y, CFG_DATA_W'(POS_LO));
        write_reg(CFG_LAST_SPARE, 24'hFFFFFF);
        end_writes();
        run_phase(150, 0, 0, 1'b0);

        // All gains at full scale, offsets swapped, long output stall
        write_reg(CFG_GAIN_PROP, 24'hFFFFFF);
        write_reg(CFG_GAIN_INTEG, 24'hFFFFFF);
        write_reg(CFG_GAIN_DERIV, 24'hFFFFFF);
        write_reg(CFG_OFFSET_X, CFG_DATA_W'(POS_LO));
        write_reg(CFG_OFFSET_Y, CFG_DATA_W'(POS_HI));
        end_writes();
        run_phase(150, 8, 8, 1'b1);

        // Random settings, mostly moderate gains
        random_config(8192, 1'b0);
        run_phase(240, 8, 0, 1'b0);
        random_config(65535, 1'b1);
        run_phase(240, 0, 8, 1'b1);
        random_config(4096, 1'b0);
        run_phase(240, 8, 8, 1'b0);
        random_config(65535, 1'b0);
        run_phase(240, 3, 3, 1'b0);
        random_config(16384, 1'b1);
        run_phase(240, 8, 8, 1'b0);

        // Let any stray result show up before the verdict
        repeat (150) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
